// ----- hdl/mbdp_pkg.sv -----
// Shared types, constants and the FP4 nibble decode for the MXFP4 block dot product.
`timescale 1ns / 1ps

package mbdp_pkg;

  localparam logic [31:0] NIB_TABLE  = 32'hC8643210;
  localparam int          SCALE_BIAS = 128;
  localparam int          SH_BITS    = 10;

  typedef struct packed {
    logic row_end;
    logic sat;
  } mbdp_ctl_t;

  function automatic logic signed [4:0] nib_value(input logic [3:0] nb);
    logic [3:0] mag;
    mag = 4'(NIB_TABLE >> {nb[2:0], 2'b00});
    return nb[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ----- hdl/mbdp_block_acc.sv -----
// Input register, FP4 products and saturating block sum with the block close register.
`timescale 1ns / 1ps

module mbdp_block_acc #(
  parameter int ACT_BITS = 16,
  parameter int ACT_FRAC = 12,
  parameter int ACC_FRAC = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [7:0]                           weight_byte_i,
  input  logic signed [ACT_BITS-1:0]           act_low_i,
  input  logic signed [ACT_BITS-1:0]           act_high_i,
  input  logic [7:0]                           scale_exp_i,
  input  logic                                 block_last_i,
  input  logic                                 row_last_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [ACT_BITS+8:0]           blk_o,
  output logic signed [mbdp_pkg::SH_BITS-1:0]  sh_o,
  output mbdp_pkg::mbdp_ctl_t                  ctl_o
);
  import mbdp_pkg::*;

  localparam int PW  = ACT_BITS + 5;
  localparam int BLK = ACT_BITS + 9;
  localparam int SH_OFF = ACC_FRAC - ACT_FRAC - SCALE_BIAS;
  localparam logic signed [BLK-1:0] BLK_MIN = {1'b1, {(BLK-1){1'b0}}};
  localparam logic signed [BLK-1:0] BLK_MAX = {1'b0, {(BLK-1){1'b1}}};

  logic                       v0_q;
  logic [7:0]                 wb_q;
  logic signed [ACT_BITS-1:0] act_lo_q;
  logic signed [ACT_BITS-1:0] act_hi_q;
  logic [7:0]                 se_q;
  logic                       blast_q;
  logic                       rlast_q;
  logic signed [BLK-1:0]      blk_q;
  logic                       blk_sat_q;
  logic                       v1_q;
  logic signed [BLK-1:0]      blk_out_q;
  logic signed [SH_BITS-1:0]  sh_q;
  mbdp_ctl_t                  ctl_q;

  logic signed [4:0]     nib_lo;
  logic signed [4:0]     nib_hi;
  logic signed [PW-1:0]  p0;
  logic signed [PW-1:0]  p1;
  logic signed [BLK:0]   s1;
  logic signed [BLK:0]   s2;
  logic signed [BLK-1:0] a1;
  logic signed [BLK-1:0] a2;
  logic                  ov1;
  logic                  ov2;
  logic                  close0;
  logic                  consume0;
  logic                  accept;
  logic signed [SH_BITS-1:0] sh_d;

  always_comb begin
    nib_lo = nib_value(wb_q[3:0]);
    nib_hi = nib_value(wb_q[7:4]);
    p0     = nib_lo * act_lo_q;
    p1     = nib_hi * act_hi_q;
    s1     = (BLK+1)'(blk_q) + (BLK+1)'(p0);
    ov1    = s1[BLK] ^ s1[BLK-1];
    a1     = ov1 ? (s1[BLK] ? BLK_MIN : BLK_MAX) : BLK'(s1);
    s2     = (BLK+1)'(a1) + (BLK+1)'(p1);
    ov2    = s2[BLK] ^ s2[BLK-1];
    a2     = ov2 ? (s2[BLK] ? BLK_MIN : BLK_MAX) : BLK'(s2);
    sh_d   = SH_BITS'(SH_OFF) + $signed(SH_BITS'(se_q));
  end

  assign close0   = blast_q | rlast_q;
  assign consume0 = v0_q && (!close0 || !v1_q || ready_i);
  assign ready_o  = !v0_q || consume0;
  assign accept   = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      blk_q     <= '0;
      blk_sat_q <= 1'b0;
    end else begin
      if (accept) begin
        v0_q <= 1'b1;
      end else if (consume0) begin
        v0_q <= 1'b0;
      end
      if (consume0 && close0) begin
        v1_q <= 1'b1;
      end else if (ready_i) begin
        v1_q <= 1'b0;
      end
      if (consume0) begin
        blk_q     <= close0 ? '0 : a2;
        blk_sat_q <= close0 ? 1'b0 : (blk_sat_q | ov1 | ov2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wb_q     <= weight_byte_i;
      act_lo_q <= act_low_i;
      act_hi_q <= act_high_i;
      se_q     <= scale_exp_i;
      blast_q  <= block_last_i;
      rlast_q  <= row_last_i;
    end
    if (consume0 && close0) begin
      blk_out_q     <= a2;
      sh_q          <= sh_d;
      ctl_q.row_end <= rlast_q;
      ctl_q.sat     <= blk_sat_q | ov1 | ov2;
    end
  end

  assign valid_o = v1_q;
  assign blk_o   = blk_out_q;
  assign sh_o    = sh_q;
  assign ctl_o   = ctl_q;

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume0 && close0 |=> blk_q == '0 && !blk_sat_q && v1_q)
    else $error("block state not cleared after a block close");

  a_open_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !(consume0 && close0) |=> !v1_q)
    else $error("block result appeared without a closing transaction");

endmodule

// ----- hdl/mbdp_scale.sv -----
// Block scale stage: power-of-two shift of the block sum into the row format, saturating.
`timescale 1ns / 1ps

module mbdp_scale #(
  parameter int ACT_BITS = 16,
  parameter int ACC_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [ACT_BITS+8:0]          blk_i,
  input  logic signed [mbdp_pkg::SH_BITS-1:0] sh_i,
  input  mbdp_pkg::mbdp_ctl_t                 ctl_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [((ACT_BITS+9 > ACC_BITS) ? ACT_BITS+9 : ACC_BITS)-1:0] val_o,
  output mbdp_pkg::mbdp_ctl_t                 ctl_o
);
  import mbdp_pkg::*;

  localparam int BLK = ACT_BITS + 9;
  localparam int SW  = (BLK > ACC_BITS) ? BLK : ACC_BITS;
  localparam int W   = ACC_BITS + BLK;
  localparam int RW  = $clog2(BLK + 1);
  localparam int LW  = $clog2(ACC_BITS);
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};

  logic                      v2_q;
  logic signed [SW-1:0]      val_q;
  mbdp_ctl_t                 ctl_q;

  logic signed [SH_BITS-1:0] r;
  logic [RW-1:0]             rsh;
  logic signed [W-1:0]       lw;
  logic                      fits;
  logic                      big;
  logic                      nonzero;
  logic signed [SW-1:0]      val_d;
  logic                      sat_d;
  logic                      load;

  always_comb begin
    r       = -sh_i;
    rsh     = (r > SH_BITS'(BLK)) ? RW'(BLK) : RW'(r);
    lw      = W'(blk_i) <<< sh_i[LW-1:0];
    fits    = (W'(ACC_BITS'(lw)) == lw);
    big     = (sh_i >= SH_BITS'(ACC_BITS));
    nonzero = |blk_i;
    sat_d   = 1'b0;
    if (sh_i[SH_BITS-1]) begin
      val_d = SW'(blk_i >>> rsh);
    end else if (nonzero && (big || !fits)) begin
      val_d = blk_i[BLK-1] ? SW'(ACC_MIN) : SW'(ACC_MAX);
      sat_d = 1'b1;
    end else begin
      val_d = SW'(ACC_BITS'(lw));
    end
  end

  assign ready_o = !v2_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (load) begin
      v2_q <= 1'b1;
    end else if (ready_i) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q         <= val_d;
      ctl_q.row_end <= ctl_i.row_end;
      ctl_q.sat     <= ctl_i.sat | sat_d;
    end
  end

  assign valid_o = v2_q;
  assign val_o   = val_q;
  assign ctl_o   = ctl_q;

  a_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && blk_i == '0 |=> val_q == '0 && ctl_q.sat == $past(ctl_i.sat))
    else $error("zero block sum scaled to a nonzero value or flagged");

endmodule

// ----- hdl/mbdp_row_acc.sv -----
// Saturating row accumulator with the sticky saturation flag and the result register.
`timescale 1ns / 1ps

module mbdp_row_acc #(
  parameter int ACT_BITS = 16,
  parameter int ACC_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [((ACT_BITS+9 > ACC_BITS) ? ACT_BITS+9 : ACC_BITS)-1:0] val_i,
  input  mbdp_pkg::mbdp_ctl_t         ctl_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [ACC_BITS-1:0]  dot_o,
  output logic                        sat_o
);
  import mbdp_pkg::*;

  localparam int BLK = ACT_BITS + 9;
  localparam int SW  = (BLK > ACC_BITS) ? BLK : ACC_BITS;
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};

  logic signed [ACC_BITS-1:0] row_q;
  logic                       sat_seen_q;
  logic                       out_v_q;
  logic signed [ACC_BITS-1:0] dot_q;
  logic                       sat_q;

  logic signed [SW:0]         sum;
  logic                       fits;
  logic signed [ACC_BITS-1:0] nxt;
  logic                       sat_all;
  logic                       consume;

  always_comb begin
    sum     = (SW+1)'(row_q) + (SW+1)'(val_i);
    fits    = ((SW+1)'(ACC_BITS'(sum)) == sum);
    nxt     = fits ? ACC_BITS'(sum) : (sum[SW] ? ACC_MIN : ACC_MAX);
    sat_all = sat_seen_q | ctl_i.sat | !fits;
  end

  assign ready_o = !ctl_i.row_end || !out_v_q || ready_i;
  assign consume = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      sat_seen_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (consume) begin
        row_q      <= ctl_i.row_end ? '0 : nxt;
        sat_seen_q <= ctl_i.row_end ? 1'b0 : sat_all;
      end
      if (consume && ctl_i.row_end) begin
        out_v_q <= 1'b1;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && ctl_i.row_end) begin
      dot_q <= nxt;
      sat_q <= sat_all;
    end
  end

  assign valid_o = out_v_q;
  assign dot_o   = dot_q;
  assign sat_o   = sat_q;

  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && ctl_i.row_end |=> out_v_q && row_q == '0 && !sat_seen_q)
    else $error("row state not cleared or result missing after row end");

endmodule

// ----- hdl/mxfp4_block_dot_product.sv -----
// Top level of the MXFP4 block dot product with stream input and output channels.
//
// Each input transaction carries one weight byte (two FP4 E2M1 weights) and the
// two Q3.12 activations they multiply, plus the block E8M0 exponent. tuser set
// closes the current block; tlast closes the block and the row.
// One output transaction is produced per row: tdata holds the saturated row dot
// product in Q23.24, tuser is set if any block sum, scale shift or row
// accumulation in that row saturated.
// The datapath is four register stages: input register, block sum, scale
// shift, row accumulator with the result register; a row result moves through
// them in that order. Throughput is one input transaction per cycle unless the
// output stalls; the block sum register and its saturation flag are the only
// feedback loops on the input side.
// Reset clears the block sum, the row sum, both saturation flags and all valid
// bits. While the output stalls with a result waiting, input transactions keep
// being accepted until a second finished row waits in front of the row stage,
// another closed block waits behind it in the block close register, and a further
// block-closing transaction sits in the input register; only then does
// s_axis_tready drop.
`timescale 1ns / 1ps

module mxfp4_block_dot_product #(
  parameter int ACT_BITS = 16,
  parameter int ACT_FRAC = 12,
  parameter int ACC_BITS = 48,
  parameter int ACC_FRAC = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // weight_byte, act_low, act_high, scale_exp from bit 0 up, zero padded to bytes.
  input  logic [((2*ACT_BITS+16+7)/8)*8-1:0] s_axis_tdata,
  // block_last.
  input  logic s_axis_tuser,
  // row_last.
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // dot_value from bit 0 up, zero padded to bytes.
  output logic [((ACC_BITS+7)/8)*8-1:0] m_axis_tdata,
  // saturated.
  output logic m_axis_tuser
);
  import mbdp_pkg::*;

  localparam int BLK    = ACT_BITS + 9;
  localparam int SW     = (BLK > ACC_BITS) ? BLK : ACC_BITS;
  localparam int OUT_TW = ((ACC_BITS + 7) / 8) * 8;

  logic                       blk_valid;
  logic                       blk_ready;
  logic signed [BLK-1:0]      blk_val;
  logic signed [SH_BITS-1:0]  blk_sh;
  mbdp_ctl_t                  blk_ctl;
  logic                       scl_valid;
  logic                       scl_ready;
  logic signed [SW-1:0]       scl_val;
  mbdp_ctl_t                  scl_ctl;
  logic signed [ACC_BITS-1:0] dot;

  mbdp_block_acc #(
    .ACT_BITS (ACT_BITS),
    .ACT_FRAC (ACT_FRAC),
    .ACC_FRAC (ACC_FRAC)
  ) u_block_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .weight_byte_i (s_axis_tdata[7:0]),
    .act_low_i     ($signed(s_axis_tdata[8 +: ACT_BITS])),
    .act_high_i    ($signed(s_axis_tdata[8+ACT_BITS +: ACT_BITS])),
    .scale_exp_i   (s_axis_tdata[8+2*ACT_BITS +: 8]),
    .block_last_i  (s_axis_tuser),
    .row_last_i    (s_axis_tlast),
    .valid_o       (blk_valid),
    .ready_i       (blk_ready),
    .blk_o         (blk_val),
    .sh_o          (blk_sh),
    .ctl_o         (blk_ctl)
  );

  mbdp_scale #(
    .ACT_BITS (ACT_BITS),
    .ACC_BITS (ACC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (blk_valid),
    .ready_o (blk_ready),
    .blk_i   (blk_val),
    .sh_i    (blk_sh),
    .ctl_i   (blk_ctl),
    .valid_o (scl_valid),
    .ready_i (scl_ready),
    .val_o   (scl_val),
    .ctl_o   (scl_ctl)
  );

  mbdp_row_acc #(
    .ACT_BITS (ACT_BITS),
    .ACC_BITS (ACC_BITS)
  ) u_row_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_valid),
    .ready_o (scl_ready),
    .val_i   (scl_val),
    .ctl_i   (scl_ctl),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .dot_o   (dot),
    .sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TW'($unsigned(dot));

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the MXFP4 block dot product stream block.
`timescale 1ns / 1ps

module tb_top;
  import mbdp_pkg::*;

  localparam int     ACT_BITS     = 16;
  localparam int     ACT_FRAC     = 12;
  localparam int     ACC_BITS     = 48;
  localparam int     ACC_FRAC     = 24;
  localparam int     BLK_BITS     = ACT_BITS + 9;
  localparam longint BLK_MAX      = (longint'(1) << (BLK_BITS - 1)) - 1;
  localparam longint ROW_MAX      = (longint'(1) << (ACC_BITS - 1)) - 1;
  localparam int     RANDOM_ITEMS = 1650;
  localparam int     IDLE_LIMIT   = 2000;
  localparam int     DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct {
    logic [7:0]         weight;
    logic signed [15:0] act_lo;
    logic signed [15:0] act_hi;
    logic [7:0]         scale;
    logic               blk_end;
    logic               row_end;
  } mx_item_t;

  typedef struct {
    logic signed [47:0] dot;
    logic               sat;
  } row_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // weight_byte, act_low, act_high, scale_exp from bit 0 up.
  logic [47:0] s_axis_tdata = '0;
  // block_last.
  logic        s_axis_tuser = 1'b0;
  // row_last.
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // dot_value.
  logic [47:0] m_axis_tdata;
  // saturated.
  logic        m_axis_tuser;

  longint      blk_acc = 0;
  longint      row_acc = 0;
  bit          row_sat = 1'b0;
  row_result_t rows_pending[$];

  int          mismatches = 0;
  int          rows_checked = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_phase = 0;
  rx_mode_e    stall_mode = RX_ALWAYS;

  mxfp4_block_dot_product #(
    .ACT_BITS(ACT_BITS),
    .ACT_FRAC(ACT_FRAC),
    .ACC_BITS(ACC_BITS),
    .ACC_FRAC(ACC_FRAC)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint fp4_weight(input logic [3:0] nb);
    longint mag;
    case (nb[2:0])
      3'd5:    mag = 6;
      3'd6:    mag = 8;
      3'd7:    mag = 12;
      default: mag = longint'(nb[2:0]);
    endcase
    return nb[3] ? -mag : mag;
  endfunction

  function automatic longint clamp_sum(input longint a, input longint b, input longint lim);
    longint s;
    s = a + b;
    if (s > lim) begin
      row_sat = 1'b1;
      return lim;
    end
    if (s < -lim - 1) begin
      row_sat = 1'b1;
      return -lim - 1;
    end
    return s;
  endfunction

  // Scales the block sum by 2^sh into the row format: floor on right shifts,
  // saturation on left shifts.
  function automatic longint scale_to_row(input longint v, input int sh);
    if (v == 0) return 0;
    if (sh < 0) begin
      if (-sh >= 63) return (v < 0) ? -1 : 0;
      return v >>> (-sh);
    end
    if (v > 0) begin
      if (sh >= 63 || v > (ROW_MAX >>> sh)) begin
        row_sat = 1'b1;
        return ROW_MAX;
      end
      return v <<< sh;
    end
    if (sh >= 63 || -v > ((ROW_MAX + 1) >>> sh)) begin
      row_sat = 1'b1;
      return -ROW_MAX - 1;
    end
    return v <<< sh;
  endfunction

  task automatic predict_row(input mx_item_t it);
    int          sh;
    row_result_t r;
    blk_acc = clamp_sum(blk_acc, fp4_weight(it.weight[3:0]) * longint'(it.act_lo), BLK_MAX);
    blk_acc = clamp_sum(blk_acc, fp4_weight(it.weight[7:4]) * longint'(it.act_hi), BLK_MAX);
    if (it.blk_end || it.row_end) begin
      sh = ACC_FRAC - ACT_FRAC + int'(it.scale) - SCALE_BIAS;
      row_acc = clamp_sum(row_acc, scale_to_row(blk_acc, sh), ROW_MAX);
      blk_acc = 0;
    end
    if (it.row_end) begin
      r.dot = row_acc[47:0];
      r.sat = row_sat;
      rows_pending.push_back(r);
      row_acc = 0;
      row_sat = 1'b0;
    end
  endtask

  task automatic send_item(input logic [7:0] wgt, input logic signed [15:0] a_lo,
                           input logic signed [15:0] a_hi, input logic [7:0] scl,
                           input logic blk_end, input logic row_end);
    mx_item_t it;
    int       gap;
    bit       taken;
    it.weight  = wgt;
    it.act_lo  = a_lo;
    it.act_hi  = a_hi;
    it.scale   = scl;
    it.blk_end = blk_end;
    it.row_end = row_end;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {scl, a_hi, a_lo, wgt};
    s_axis_tuser  <= blk_end;
    s_axis_tlast  <= row_end;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    predict_row(it);
    items_sent++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch on row %0d: %s", rows_checked, msg);
    mismatches++;
  endtask

  // Every nibble code once, with zero, floor to -1, out-of-reach right shift,
  // saturation at scale 255 both ways, and a row end without a block end.
  task automatic test_nibble_and_scale();
    logic [7:0] scl[8];
    scl = '{8'd255, 8'd0, 8'd255, 8'd178, 8'd53, 8'd255, 8'd139, 8'd116};
    for (int i = 0; i < 8; i++) begin
      send_item({4'(8 + i), 4'(i)}, i[0] ? 16'sh8000 : 16'sh7fff,
                i[0] ? 16'sh7fff : 16'sh8000, scl[i], i != 7, i == 3 || i == 7);
    end
  endtask

  // A block that never sees its end marker saturates the block sum.
  task automatic test_overlong_block();
    for (int i = 0; i < 22; i++) begin
      send_item(8'h77, 16'sh7fff, 16'sh7fff, 8'd116, 1'b0, i == 21);
    end
  endtask

  task automatic test_random_rows();
    int                 stop_at;
    int                 n_blk;
    int                 len;
    int                 mode;
    bit                 heavy;
    bit                 neg_w;
    bit                 neg_a;
    bit                 last;
    logic [7:0]         scl;
    logic [7:0]         wgt;
    logic signed [15:0] a_lo;
    logic signed [15:0] a_hi;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          send_item(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                    1'($urandom_range(0, 1)), k == len - 1);
        end
      end else begin
        n_blk = $urandom_range(1, 3);
        for (int b = 0; b < n_blk; b++) begin
          mode  = $urandom_range(0, 9);
          len   = (mode == 0) ? $urandom_range(17, 30) :
                  (mode == 1) ? $urandom_range(1, 15) : 16;
          heavy = (mode == 0) || ($urandom_range(0, 7) == 0);
          neg_w = $urandom_range(0, 1);
          neg_a = $urandom_range(0, 1);
          scl   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(96, 136));
          for (int k = 0; k < len; k++) begin
            last = (k == len - 1);
            if (heavy) begin
              wgt  = neg_w ? 8'hFF : 8'h77;
              a_lo = neg_a ? 16'sh8000 : 16'sh7fff;
              a_hi = a_lo;
            end else begin
              wgt  = 8'($urandom);
              a_lo = 16'($urandom);
              a_hi = 16'($urandom);
            end
            send_item(wgt, a_lo, a_hi, last ? scl : 8'($urandom),
                      last && (b != n_blk - 1 || $urandom_range(0, 1) == 1),
                      last && (b == n_blk - 1));
          end
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  <= rx_mode_e'($urandom_range(0, 3));
      stall_phase <= $urandom_range(16, 96);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= (stall_phase % 16) > 9;
    endcase
  end

  always @(negedge clk_i) begin : check_rows
    row_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rows_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result dot_value %0d",
                                  $signed(m_axis_tdata)));
      end else begin
        want = rows_pending.pop_front();
        if (m_axis_tdata !== want.dot) begin
          report_mismatch($sformatf("dot_value got %0d want %0d",
                                    $signed(m_axis_tdata), want.dot));
        end
        if (m_axis_tuser !== want.sat) begin
          report_mismatch($sformatf("saturated got %b want %b", m_axis_tuser, want.sat));
        end
      end
      rows_checked++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_nibble_and_scale();
    test_overlong_block();
    test_random_rows();
    s_axis_tvalid <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
